// ===== rtl/core/z_ordered_circle_hit_table_assert.svh =====
`ifndef Z_ORDERED_CIRCLE_HIT_TABLE_ASSERT_SVH
`define Z_ORDERED_CIRCLE_HIT_TABLE_ASSERT_SVH

// Both macros expect clk and rst_n in the scope where they are used.
`define ZOHT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zoht assertion failed");

`define ZOHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zoht assertion failed");

`endif

// ===== rtl/core/zoht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package zoht_pkg;

    localparam int DEPTH_DEF       = 32;
    localparam int COORD_BITS_DEF  = 12;
    localparam int RADIUS_BITS_DEF = 10;

    localparam int FUNC_BITS   = 3;
    localparam int STATUS_BITS = 2;
    localparam int INDEX_BITS  = 5;
    localparam int COUNT_BITS  = 6;

    typedef enum logic [FUNC_BITS-1:0] {
        FN_MOVE      = 3'd0,
        FN_PRESS     = 3'd1,
        FN_RELEASE   = 3'd2,
        FN_DEL_HOVER = 3'd3,
        FN_DEL_LAST  = 3'd4,
        FN_APPEND    = 3'd5,
        FN_INSERT    = 3'd6
    } func_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NO_DELETE = 2'd2,
        ST_NOW_EMPTY = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic dispatch;
        logic walk;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic needs_walk;
        logic walk_done;
        logic found;
        logic pipe_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/zoht_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface zoht_in_if
    import zoht_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [FUNC_BITS-1:0]   func;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [RADIUS_BITS-1:0] new_radius;

    modport source (
        output valid,
        output func,
        output pos_x,
        output pos_y,
        output new_radius,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  pos_x,
        input  pos_y,
        input  new_radius,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/zoht_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface zoht_out_if
    import zoht_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic                   hover_valid;
    logic [INDEX_BITS-1:0]  hover_index;
    logic                   grab_valid;
    logic [COUNT_BITS-1:0]  circle_count;

    modport source (
        output valid,
        output status,
        output hover_valid,
        output hover_index,
        output grab_valid,
        output circle_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  status,
        input  hover_valid,
        input  hover_index,
        input  grab_valid,
        input  circle_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/zoht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zoht_ctrl
    import zoht_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_WALK     = 6'b000100,
        S_DRAIN    = 6'b001000,
        S_FINISH   = 6'b010000,
        S_RESULT   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                state_next   = stat.needs_walk ? S_WALK : S_RESULT;
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done || stat.found)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_RESULT);

endmodule

`default_nettype wire

// ===== rtl/core/zoht_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module zoht_datapath
    import zoht_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic [FUNC_BITS-1:0]   func,
    input  logic [COORD_BITS-1:0]  pos_x,
    input  logic [COORD_BITS-1:0]  pos_y,
    input  logic [RADIUS_BITS-1:0] new_radius,
    output logic [STATUS_BITS-1:0] status,
    output logic                   hover_valid,
    output logic [INDEX_BITS-1:0]  hover_index,
    output logic                   grab_valid,
    output logic [COUNT_BITS-1:0]  circle_count
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int RSQ_W = 2 * RADIUS_BITS;
    localparam int CMP_W = (SQ_W + 1 > RSQ_W) ? SQ_W + 1 : RSQ_W;

    logic [COORD_BITS-1:0]  x_mem [DEPTH];
    logic [COORD_BITS-1:0]  y_mem [DEPTH];
    logic [RADIUS_BITS-1:0] r_mem [DEPTH];

    func_t                  func_reg;
    logic [COORD_BITS-1:0]  x_reg;
    logic [COORD_BITS-1:0]  y_reg;
    logic [RADIUS_BITS-1:0] r_reg;

    logic [CW-1:0] count_reg, count_next;
    logic          hv_reg, hv_next;
    logic [AW-1:0] hp_reg, hp_next;
    logic          gv_reg, gv_next;
    logic [AW-1:0] gp_reg, gp_next;
    status_t       status_reg, status_next;
    logic          found_reg, found_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic          v1_reg, v1_next;
    logic          v2_reg, v2_next;
    logic          v3_reg, v3_next;

    logic [AW-1:0]          tag1_reg, tag2_reg, tag3_reg;
    logic [COORD_BITS-1:0]  rd_x_reg, rd_y_reg;
    logic [RADIUS_BITS-1:0] rd_r_reg;
    logic [COORD_BITS-1:0]  dx_reg, dy_reg;
    logic [RADIUS_BITS-1:0] rad_reg;
    logic [SQ_W-1:0]        sqx_reg, sqy_reg;
    logic [RSQ_W-1:0]       sqr_reg;

    logic [CW-1:0] hp_ext;
    logic [CW-1:0] gp_ext;
    logic [CW-1:0] cnt_m1;
    logic [CW-1:0] ins_pos_w;
    logic          hover_live;
    logic          full;
    logic          issue;
    logic          hit;
    logic          shift_wr;

    logic                   wr_en;
    logic                   wr_r_en;
    logic [AW-1:0]          wr_addr;
    logic [COORD_BITS-1:0]  wr_x;
    logic [COORD_BITS-1:0]  wr_y;
    logic [RADIUS_BITS-1:0] wr_r;

    assign hp_ext     = CW'(hp_reg);
    assign gp_ext     = CW'(gp_reg);
    assign cnt_m1     = count_reg - CW'(1);
    assign hover_live = hv_reg && (hp_ext < count_reg);
    assign full       = (count_reg == CW'(DEPTH));
    assign ins_pos_w  = hover_live ? (hp_ext + CW'(1)) : '0;
    assign issue      = cmd.walk && (rem_reg != '0) && !found_reg;
    assign hit        = v3_reg && !found_reg &&
                        ((CMP_W'(sqx_reg) + CMP_W'(sqy_reg)) <= CMP_W'(sqr_reg));
    assign shift_wr   = v1_reg && (func_reg != FN_MOVE);

    assign stat.needs_walk = (func_reg == FN_MOVE) ||
                             ((func_reg == FN_DEL_HOVER) && hover_live) ||
                             ((func_reg == FN_INSERT) && !full);
    assign stat.walk_done  = (rem_reg == '0);
    assign stat.found      = found_reg;
    assign stat.pipe_busy  = v1_reg || v2_reg || v3_reg;

    always_comb
    begin
        count_next  = count_reg;
        hv_next     = hv_reg;
        hp_next     = hp_reg;
        gv_next     = gv_reg;
        gp_next     = gp_reg;
        status_next = status_reg;
        found_next  = found_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        pos_next    = pos_reg;
        v1_next     = issue;
        v2_next     = v1_reg && (func_reg == FN_MOVE);
        v3_next     = v2_reg;

        if (cmd.load)
        begin
            found_next  = 1'b0;
            status_next = ST_DONE;
        end

        if (cmd.dispatch)
        begin
            unique case (func_reg)
                FN_MOVE:
                begin
                    hv_next  = 1'b0;
                    hp_next  = '0;
                    idx_next = cnt_m1[AW-1:0];
                    rem_next = count_reg;
                end
                FN_PRESS:
                begin
                    if (gv_reg)
                    begin
                        gv_next = 1'b0;
                        gp_next = '0;
                    end
                    else
                    begin
                        gv_next = hv_reg;
                        gp_next = hv_reg ? hp_reg : '0;
                    end
                end
                FN_RELEASE:
                begin
                    gv_next = 1'b0;
                    gp_next = '0;
                end
                FN_DEL_HOVER:
                begin
                    gv_next = 1'b0;
                    gp_next = '0;
                    if (hover_live)
                    begin
                        idx_next = AW'(hp_ext + CW'(1));
                        rem_next = cnt_m1 - hp_ext;
                    end
                    else
                    begin
                        status_next = ST_NO_DELETE;
                    end
                end
                FN_DEL_LAST:
                begin
                    gv_next = 1'b0;
                    gp_next = '0;
                    if (count_reg == '0)
                    begin
                        status_next = ST_NO_DELETE;
                    end
                    else
                    begin
                        count_next = cnt_m1;
                        if (hv_reg && (hp_ext >= cnt_m1))
                        begin
                            hv_next = 1'b0;
                            hp_next = '0;
                        end
                        status_next = (cnt_m1 == '0) ? ST_NOW_EMPTY : ST_DONE;
                    end
                end
                FN_APPEND:
                begin
                    gv_next = 1'b0;
                    gp_next = '0;
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                FN_INSERT:
                begin
                    gv_next = 1'b0;
                    gp_next = '0;
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        pos_next = ins_pos_w[AW-1:0];
                        idx_next = cnt_m1[AW-1:0];
                        rem_next = count_reg - ins_pos_w;
                    end
                end
                default:
                begin
                    gv_next = 1'b0;
                    gp_next = '0;
                end
            endcase
        end

        if (issue)
        begin
            idx_next = (func_reg == FN_DEL_HOVER) ? (idx_reg + AW'(1)) : (idx_reg - AW'(1));
            rem_next = rem_reg - CW'(1);
        end

        // Entries arrive top first, so the first hit is the topmost circle.
        if (hit)
        begin
            found_next = 1'b1;
            hv_next    = 1'b1;
            hp_next    = tag3_reg;
        end

        if (cmd.finish)
        begin
            if (func_reg == FN_DEL_HOVER)
            begin
                count_next  = cnt_m1;
                hv_next     = 1'b0;
                hp_next     = '0;
                status_next = (cnt_m1 == '0) ? ST_NOW_EMPTY : ST_DONE;
            end
            else if (func_reg == FN_INSERT)
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_r_en = 1'b0;
        wr_addr = '0;
        wr_x    = x_reg;
        wr_y    = y_reg;
        wr_r    = r_reg;
        priority if (shift_wr)
        begin
            wr_en   = 1'b1;
            wr_r_en = 1'b1;
            wr_addr = (func_reg == FN_DEL_HOVER) ? (tag1_reg - AW'(1)) : (tag1_reg + AW'(1));
            wr_x    = rd_x_reg;
            wr_y    = rd_y_reg;
            wr_r    = rd_r_reg;
        end
        else if (cmd.dispatch && (func_reg == FN_MOVE) && gv_reg && (gp_ext < count_reg))
        begin
            wr_en   = 1'b1;
            wr_addr = gp_reg;
        end
        else if (cmd.dispatch && (func_reg == FN_APPEND) && !full)
        begin
            wr_en   = 1'b1;
            wr_r_en = 1'b1;
            wr_addr = count_reg[AW-1:0];
        end
        else if (cmd.finish && (func_reg == FN_INSERT))
        begin
            wr_en   = 1'b1;
            wr_r_en = 1'b1;
            wr_addr = pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            x_mem[wr_addr] <= wr_x;
            y_mem[wr_addr] <= wr_y;
        end
        if (wr_r_en)
        begin
            r_mem[wr_addr] <= wr_r;
        end
        rd_x_reg <= x_mem[idx_reg];
        rd_y_reg <= y_mem[idx_reg];
        rd_r_reg <= r_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= pos_x;
            y_reg <= pos_y;
            r_reg <= new_radius;
        end
        tag1_reg <= idx_reg;
        tag2_reg <= tag1_reg;
        tag3_reg <= tag2_reg;
        dx_reg   <= (x_reg >= rd_x_reg) ? (x_reg - rd_x_reg) : (rd_x_reg - x_reg);
        dy_reg   <= (y_reg >= rd_y_reg) ? (y_reg - rd_y_reg) : (rd_y_reg - y_reg);
        rad_reg  <= rd_r_reg;
        sqx_reg  <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg  <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        sqr_reg  <= RSQ_W'(rad_reg) * RSQ_W'(rad_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            func_reg   <= FN_MOVE;
            count_reg  <= '0;
            hv_reg     <= 1'b0;
            hp_reg     <= '0;
            gv_reg     <= 1'b0;
            gp_reg     <= '0;
            status_reg <= ST_DONE;
            found_reg  <= 1'b0;
            idx_reg    <= '0;
            rem_reg    <= '0;
            pos_reg    <= '0;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                func_reg <= func_t'(func);
            end
            count_reg  <= count_next;
            hv_reg     <= hv_next;
            hp_reg     <= hp_next;
            gv_reg     <= gv_next;
            gp_reg     <= gp_next;
            status_reg <= status_next;
            found_reg  <= found_next;
            idx_reg    <= idx_next;
            rem_reg    <= rem_next;
            pos_reg    <= pos_next;
            v1_reg     <= v1_next;
            v2_reg     <= v2_next;
            v3_reg     <= v3_next;
        end
    end

    assign status       = status_reg;
    assign hover_valid  = hv_reg;
    assign hover_index  = hv_reg ? INDEX_BITS'(hp_reg) : '0;
    assign grab_valid   = gv_reg;
    assign circle_count = COUNT_BITS'(count_reg);

endmodule

`default_nettype wire

// ===== rtl/core/z_ordered_circle_hit_table.sv =====
// Button, delete last, append and refused events: the result word is offered straight after
// dispatch, with no table walk.
// Pointer move: the hit test reads one entry per cycle of the N circles held, top entry first.
// Delete hovered and insert: the K entries being shifted are walked, then the pipeline drains.
// One word is in flight at a time; the next is accepted once the result word is taken.
// Reset (rst_n, asynchronous, active low) empties the table and clears hover and grab.
`timescale 1ns / 1ps
`default_nettype none

`include "z_ordered_circle_hit_table_assert.svh"

module z_ordered_circle_hit_table
    import zoht_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int RADIUS_BITS = RADIUS_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    zoht_in_if.sink     req,
    zoht_out_if.source  rsp
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    zoht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    zoht_datapath #(
        .DEPTH       (DEPTH),
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .func         (req.func),
        .pos_x        (req.pos_x),
        .pos_y        (req.pos_y),
        .new_radius   (req.new_radius),
        .status       (rsp.status),
        .hover_valid  (rsp.hover_valid),
        .hover_index  (rsp.hover_index),
        .grab_valid   (rsp.grab_valid),
        .circle_count (rsp.circle_count)
    );

    `ZOHT_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready && !rsp.valid)
    `ZOHT_ASSERT_SAME(a_one_word_in_flight, rsp.valid, !req.ready)
    `ZOHT_ASSERT_SAME(a_no_grab_on_table_status, rsp.valid && (rsp.status != ST_DONE), !rsp.grab_valid)

endmodule

`default_nettype wire
